// ----- src/dbh_pkg.sv -----
// Shared types, codes and reset values for the debouncer with hold detection.
package dbh_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int TIME_OUT_W     = 32;
    localparam int INC_W          = 16;
    localparam int HOLD_W         = 32;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic ONE_IS_UP = 1'b1;

    typedef enum logic [1:0] {
        ST_UP      = 2'd0,
        ST_FALLING = 2'd1,
        ST_DOWN    = 2'd2,
        ST_RISING  = 2'd3
    } fsm_state_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_HOLD     = 3'd3,
        EV_HANDLED  = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ACK     = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTIVE_HIGH    = 3'd0,
        CFG_TICK_INCREMENT = 3'd1,
        CFG_PRESS_ENABLE   = 3'd2,
        CFG_RELEASE_ENABLE = 3'd3,
        CFG_HOLD_ENABLE    = 3'd4,
        CFG_HOLD_LIMIT     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic              active_high;
        logic [INC_W-1:0]  tick_increment;
        logic              press_enable;
        logic              release_enable;
        logic              hold_enable;
        logic [HOLD_W-1:0] hold_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        active_high:    1'b1,
        tick_increment: 16'd1,
        press_enable:   1'b1,
        release_enable: 1'b1,
        hold_enable:    1'b0,
        hold_limit:     32'd1000
    };

    typedef struct packed {
        fsm_state_t fsm_state;
        event_t     event_code;
        logic       press_pulse;
        logic       release_pulse;
        logic       hold_pulse;
    } step_res_t;

endpackage

// ----- src/dbh_if.sv -----
// Request channel interfaces: sample input, result output and configuration write.
interface dbh_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       pin_level;

    modport source (output valid, output opcode, output pin_level, input ready);
    modport sink   (input valid, input opcode, input pin_level, output ready);
endinterface

interface dbh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fsm_state;
    logic [2:0]  event_code;
    logic [31:0] time_in_state;
    logic        press_pulse;
    logic        release_pulse;
    logic        hold_pulse;

    modport source (output valid, output fsm_state, output event_code, output time_in_state,
                    output press_pulse, output release_pulse, output hold_pulse, input ready);
    modport sink   (input valid, input fsm_state, input event_code, input time_in_state,
                    input press_pulse, input release_pulse, input hold_pulse, output ready);
endinterface

interface dbh_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/dbh_core.sv -----
// Debounce state machine: state registers and single-step next-value logic.
module dbh_core #(
    parameter int TIME_WIDTH = dbh_pkg::TIME_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [1:0]            opcode,
    input  logic                  pin_level,
    input  dbh_pkg::cfg_t         cfg,
    output dbh_pkg::step_res_t    res,
    output logic [TIME_WIDTH-1:0] elapsed_out
);
    import dbh_pkg::*;

    localparam int SUM_W = ((TIME_WIDTH > INC_W) ? TIME_WIDTH : INC_W) + 1;
    localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;
    localparam logic [SUM_W-1:0] TIME_MAX_EXT =
        {{(SUM_W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

    fsm_state_t            state_reg, state_next, tick_state;
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next, elapsed_sat;
    logic [3:0]            flags_reg, flags_next, flags_tick, bit_sel;
    event_t                event_reg, event_next;
    logic                  up, entering, changed, hold_over;
    logic                  press_p, release_p, hold_p;
    logic [SUM_W-1:0]      sum;

    always_comb
    begin
        up          = (cfg.active_high == ONE_IS_UP) ? pin_level : ~pin_level;
        bit_sel     = 4'b0001 << state_reg;
        entering    = (flags_reg & bit_sel) == 4'b0000;
        sum         = SUM_W'(elapsed_reg) + SUM_W'(cfg.tick_increment);
        elapsed_sat = (sum > TIME_MAX_EXT) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
        hold_over   = CMP_W'(elapsed_sat) > CMP_W'(cfg.hold_limit);
    end

    // next state
    always_comb
    begin
        tick_state = state_reg;
        unique case (state_reg)
            ST_UP:      if (!up) tick_state = ST_FALLING;
            ST_DOWN:    if (up) tick_state = ST_RISING;
            ST_FALLING: tick_state = up ? ST_UP : ST_DOWN;
            ST_RISING:  tick_state = up ? ST_UP : ST_DOWN;
            default:    tick_state = state_reg;
        endcase
        changed = tick_state != state_reg;

        state_next = state_reg;
        unique case (opcode)
            OP_TICK:    state_next = tick_state;
            OP_RESTART: state_next = up ? ST_UP : ST_DOWN;
            default:    state_next = state_reg;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        elapsed_next = elapsed_reg;
        flags_next   = flags_reg;
        event_next   = event_reg;
        flags_tick   = flags_reg | bit_sel;
        press_p      = 1'b0;
        release_p    = 1'b0;
        hold_p       = 1'b0;
        unique case (opcode)
            OP_TICK:
            begin
                if ((state_reg == ST_UP || state_reg == ST_DOWN) && entering)
                    event_next = EV_NONE;
                unique case (state_reg)
                    ST_DOWN:
                    begin
                        if (cfg.hold_enable && hold_over && event_next == EV_NONE)
                        begin
                            event_next = EV_HOLD;
                            hold_p     = 1'b1;
                        end
                    end
                    ST_FALLING:
                    begin
                        if (!up && cfg.press_enable)
                        begin
                            event_next = EV_PRESSED;
                            press_p    = 1'b1;
                        end
                    end
                    ST_RISING:
                    begin
                        if (up && cfg.release_enable)
                        begin
                            event_next = EV_RELEASED;
                            release_p  = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (changed)
                begin
                    flags_next   = flags_tick & ~bit_sel;
                    elapsed_next = '0;
                    if (state_reg == ST_UP || state_reg == ST_DOWN)
                        event_next = EV_NONE;
                end
                else
                begin
                    flags_next   = flags_tick;
                    elapsed_next = elapsed_sat;
                end
            end
            OP_ACK:
                event_next = EV_HANDLED;
            OP_RESTART:
            begin
                elapsed_next = '0;
                flags_next   = 4'b0000;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_UP;
            elapsed_reg <= '0;
            flags_reg   <= 4'b0000;
            event_reg   <= EV_NONE;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            flags_reg   <= flags_next;
            event_reg   <= event_next;
        end
    end

    assign res.fsm_state     = state_next;
    assign res.event_code    = event_next;
    assign res.press_pulse   = press_p;
    assign res.release_pulse = release_p;
    assign res.hold_pulse    = hold_p;
    assign elapsed_out       = elapsed_next;

endmodule

// ----- src/debounce_with_hold_detect.sv -----
// Top level of the debouncer with hold detection: channels, configuration and pipeline.
//
// Usage:
//   sample : request channel carrying opcode (tick, acknowledge, restart) and pin_level.
//   result : one request per accepted sample with fsm_state, event_code, time_in_state
//            and the press, release and hold pulses of that step.
//   cfg    : register writes, index 0..5 as active_high, tick_increment, press_enable,
//            release_enable, hold_enable, hold_limit; always ready. Write only while idle.
// Pipeline: a sample lands in the input register, is stepped through the state machine
//   when the output register can take it, and its result then stands in the output register.
// Throughput: one sample per cycle while result is taken; the state update is one
//   saturating add and one compare between the input and output registers.
// Reset: state up, time zero, entry flags and last event cleared, registers to defaults.
// Stall: when result is not taken the output register holds, the input register fills
//   and then sample ready drops; no request is lost or repeated.
module debounce_with_hold_detect #(
    parameter int TIME_WIDTH = dbh_pkg::TIME_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    dbh_in_if.sink      sample,
    dbh_out_if.source   result,
    dbh_cfg_if.sink     cfg
);
    import dbh_pkg::*;

    localparam int OUT_W = (TIME_WIDTH > TIME_OUT_W) ? TIME_WIDTH : TIME_OUT_W;

    cfg_t                  cfg_reg;
    logic                  in_valid_reg, in_valid_next;
    logic [1:0]            opcode_reg;
    logic                  pin_reg;
    logic                  out_valid_reg, out_valid_next;
    step_res_t             res_reg, res_step;
    logic [TIME_OUT_W-1:0] time_reg;
    logic [TIME_WIDTH-1:0] elapsed_step;
    logic [OUT_W-1:0]      elapsed_ext;
    logic                  advance, fire, in_accept;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ACTIVE_HIGH:    cfg_reg.active_high    <= cfg.data[0];
                CFG_TICK_INCREMENT: cfg_reg.tick_increment <= cfg.data[INC_W-1:0];
                CFG_PRESS_ENABLE:   cfg_reg.press_enable   <= cfg.data[0];
                CFG_RELEASE_ENABLE: cfg_reg.release_enable <= cfg.data[0];
                CFG_HOLD_ENABLE:    cfg_reg.hold_enable    <= cfg.data[0];
                CFG_HOLD_LIMIT:     cfg_reg.hold_limit     <= cfg.data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    // pipeline control
    always_comb
    begin
        advance        = !out_valid_reg || result.ready;
        fire           = in_valid_reg && advance;
        sample.ready   = !in_valid_reg || advance;
        in_accept      = sample.valid && sample.ready;
        in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            opcode_reg <= sample.opcode;
            pin_reg    <= sample.pin_level;
        end
        if (fire)
        begin
            res_reg  <= res_step;
            time_reg <= elapsed_ext[TIME_OUT_W-1:0];
        end
    end

    dbh_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .opcode      (opcode_reg),
        .pin_level   (pin_reg),
        .cfg         (cfg_reg),
        .res         (res_step),
        .elapsed_out (elapsed_step)
    );

    assign elapsed_ext          = OUT_W'(elapsed_step);
    assign result.valid         = out_valid_reg;
    assign result.fsm_state     = res_reg.fsm_state;
    assign result.event_code    = res_reg.event_code;
    assign result.time_in_state = time_reg;
    assign result.press_pulse   = res_reg.press_pulse;
    assign result.release_pulse = res_reg.release_pulse;
    assign result.hold_pulse    = res_reg.hold_pulse;

    a_pulse_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $onehot0({result.press_pulse, result.release_pulse,
                                   result.hold_pulse}))
        else $error("more than one pulse in a result");

    a_press_down: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.press_pulse) |->
            (result.fsm_state == ST_DOWN && result.event_code == EV_PRESSED &&
             result.time_in_state == '0))
        else $error("press pulse without entry to down");

    a_release_up: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.release_pulse) |->
            (result.fsm_state == ST_UP && result.event_code == EV_RELEASED &&
             result.time_in_state == '0))
        else $error("release pulse without entry to up");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |-> !sample.ready)
        else $error("sample taken while both stages are full");

endmodule
